/* rtl/core/lu_pivot_linear_solver_top_macros.svh */
// ----------------------------------------------------------------------------
// LU solver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LU_PIVOT_LINEAR_SOLVER_TOP_MACROS_SVH
`define LU_PIVOT_LINEAR_SOLVER_TOP_MACROS_SVH

// Same-cycle implication.
`define LUPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LUPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lups_pkg.sv */
// ----------------------------------------------------------------------------
// LU solver package
// Shared constants, command and status types, and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lups_pkg;

  localparam int unsigned MaxOrder = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DataW    = 32;

  typedef enum logic [4:0] {
    DOP_NONE,
    DOP_LOAD_RHS,
    DOP_PERM_INIT,
    DOP_SEARCH,
    DOP_PERM_CAP,
    DOP_PERM_FROM_BEST,
    DOP_PERM_PUT,
    DOP_CAP_A,
    DOP_CAP_B,
    DOP_DIV_MAT,
    DOP_CAP_L,
    DOP_MUL_L,
    DOP_X_FROM_RHS,
    DOP_ACC_LOAD_X,
    DOP_MUL_X,
    DOP_ACC_SUB,
    DOP_X_FROM_ACC,
    DOP_ACC_CLEAR,
    DOP_ACC_ADD,
    DOP_DIV_BACK,
    DOP_X_FROM_QUOT,
    DOP_EMIT,
    DOP_EMIT_SING
  } dop_e;

  typedef enum logic [2:0] {
    WSEL_IN,
    WSEL_RDATA,
    WSEL_TA,
    WSEL_QUOT,
    WSEL_SUB
  } wsel_e;

  typedef struct packed {
    dop_e            op;
    logic            rd;
    logic            wr;
    wsel_e           wsel;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            first;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] best;
    logic            piv_zero;
    logic            rdata_zero;
    logic            div_done;
    logic            out_free;
  } sts_t;

  function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
    mag32 = v[DataW-1] ? (~v + 1'b1) : v;
  endfunction

  // Signed saturation of a magnitude with a sign.
  function automatic logic [DataW-1:0] sat_signed(input logic [47:0] m, input logic neg);
    if (!neg) begin
      sat_signed = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[DataW-1:0];
    end else begin
      sat_signed = (m >= 48'h0000_8000_0000) ? 32'h8000_0000 : (~m[DataW-1:0] + 1'b1);
    end
  endfunction

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

  function automatic logic [DataW-1:0] sat_sub(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_sub = s[DataW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_sub = s[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lups_div.sv */
// ----------------------------------------------------------------------------
// LU solver divider
// Bit-serial restoring Q16.16 divider, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module lups_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lups_pkg::DataW-1:0]  a_i,
  input  logic [lups_pkg::DataW-1:0]  b_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [lups_pkg::DataW-1:0]  quot_o
);
  import lups_pkg::*;

  localparam int unsigned Steps = 48;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [47:0]       num_q, num_d;
  logic [DataW-1:0]  rem_q, rem_d;
  logic [DataW-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic [DataW-1:0]  mag_b;
  logic [DataW:0]    rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    mag_b  = mag32(b_i);
    rem_sh = {rem_q, num_q[47]};
    if (start_i) begin
      // Rounding adds half the divisor to the scaled dividend up front.
      num_d  = {mag32(a_i), 16'h0000} + {17'h00000, mag_b[DataW-1:1]};
      den_d  = mag_b;
      rem_d  = '0;
      cnt_d  = '0;
      neg_d  = a_i[DataW-1] ^ b_i[DataW-1];
      zero_d = (mag_b == '0);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 32'(rem_sh - {1'b0, den_q});
        num_d = {num_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh[DataW-1:0];
        num_d = {num_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : sat_signed(num_q, neg_q);

endmodule

`default_nettype wire

/* rtl/core/lups_dp.sv */
// ----------------------------------------------------------------------------
// LU solver datapath
// Matrix memory, vectors, multiplier, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lu_pivot_linear_solver_top_macros.svh"

module lups_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lups_pkg::cmd_t              cmd_i,
  input  logic [lups_pkg::DataW-1:0]  value_i,
  output lups_pkg::sts_t              sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lups_pkg::DataW-1:0]  out_solution_o,
  output logic [lups_pkg::IdxW-1:0]   out_index_o,
  output logic                        out_singular_o,
  output logic                        out_last_o
);
  import lups_pkg::*;

  localparam int unsigned Depth = MaxOrder * MaxOrder;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] rhs_q  [MaxOrder];
  logic [DataW-1:0] x_q    [MaxOrder];
  logic [IdxW-1:0]  perm_q [MaxOrder];

  logic [DataW-1:0] ta_q, tb_q, l_q, acc_q, bmag_q;
  logic [IdxW-1:0]  best_q, pa_q;
  logic signed [63:0] prod_q;
  logic               mneg_q;
  logic [DataW-1:0]   mres_q;

  logic [7:0]       addr;
  logic [DataW-1:0] wdata, xr, cand, mul_a, mul_b, div_a, div_b, quot;
  logic [IdxW-1:0]  xaddr, paddr;
  logic [63:0]      pmag, prnd;
  logic             div_start, div_busy, div_done;
  logic             out_valid_q, out_free;
  logic             emit;

  assign addr  = {cmd_i.row, cmd_i.col};
  assign xaddr = (cmd_i.op == DOP_MUL_X) ? cmd_i.col : cmd_i.row;
  assign xr    = x_q[xaddr];
  assign paddr = (cmd_i.op == DOP_PERM_FROM_BEST) ? best_q : cmd_i.row;
  assign cand  = mag32(rdata_q);
  assign emit  = (cmd_i.op == DOP_EMIT) || (cmd_i.op == DOP_EMIT_SING);

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_IN:    wdata = value_i;
      WSEL_RDATA: wdata = rdata_q;
      WSEL_TA:    wdata = ta_q;
      WSEL_QUOT:  wdata = quot;
      WSEL_SUB:   wdata = sat_sub(tb_q, mres_q);
      default:    wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Multiplier: product register, then round and saturate.
  assign mul_a = (cmd_i.op == DOP_MUL_L) ? l_q : rdata_q;
  assign mul_b = (cmd_i.op == DOP_MUL_L) ? rdata_q : xr;
  assign pmag  = prod_q[63] ? (~prod_q + 1'b1) : prod_q;
  assign prnd  = (pmag + 64'd32768) >> 16;

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == DOP_MUL_L) || (cmd_i.op == DOP_MUL_X)) begin
      prod_q <= $signed(mul_a) * $signed(mul_b);
      mneg_q <= mul_a[DataW-1] ^ mul_b[DataW-1];
    end
    mres_q <= sat_signed(prnd[47:0], mneg_q);
  end

  assign div_start = (cmd_i.op == DOP_DIV_MAT) || (cmd_i.op == DOP_DIV_BACK);
  assign div_a     = (cmd_i.op == DOP_DIV_BACK) ? sat_sub(xr, acc_q) : rdata_q;
  assign div_b     = (cmd_i.op == DOP_DIV_BACK) ? rdata_q : tb_q;

  lups_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DOP_LOAD_RHS: rhs_q[cmd_i.col] <= value_i;
      DOP_PERM_INIT: begin
        for (int i = 0; i < MaxOrder; i++) begin
          perm_q[i] <= IdxW'(i);
        end
      end
      DOP_SEARCH: begin
        if (cmd_i.first || (cand > bmag_q)) begin
          bmag_q <= cand;
          best_q <= cmd_i.row;
        end
      end
      DOP_PERM_CAP:       pa_q <= perm_q[paddr];
      DOP_PERM_FROM_BEST: perm_q[cmd_i.row] <= perm_q[paddr];
      DOP_PERM_PUT:       perm_q[cmd_i.row] <= pa_q;
      DOP_CAP_A:          ta_q <= rdata_q;
      DOP_CAP_B:          tb_q <= rdata_q;
      DOP_CAP_L:          l_q <= quot;
      DOP_X_FROM_RHS:     x_q[cmd_i.row] <= rhs_q[pa_q];
      DOP_ACC_LOAD_X:     acc_q <= xr;
      DOP_ACC_SUB:        acc_q <= sat_sub(acc_q, mres_q);
      DOP_ACC_ADD:        acc_q <= sat_add(acc_q, mres_q);
      DOP_ACC_CLEAR:      acc_q <= '0;
      DOP_X_FROM_ACC:     x_q[cmd_i.row] <= acc_q;
      DOP_X_FROM_QUOT:    x_q[cmd_i.row] <= quot;
      DOP_EMIT:           rhs_q[cmd_i.row] <= xr;
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_solution_o <= (cmd_i.op == DOP_EMIT) ? xr : '0;
      out_index_o    <= (cmd_i.op == DOP_EMIT) ? cmd_i.row : '0;
      out_singular_o <= (cmd_i.op == DOP_EMIT_SING);
      out_last_o     <= (cmd_i.op == DOP_EMIT_SING) || cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.best       = best_q;
  assign sts_o.piv_zero   = (bmag_q == '0);
  assign sts_o.rdata_zero = (rdata_q == '0);
  assign sts_o.div_done   = div_done && !div_busy;
  assign sts_o.out_free   = out_free;

  `LUPS_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divide issued while divider busy")
  `LUPS_ASSERT_IMP(a_acc_mul, (cmd_i.op == DOP_ACC_SUB) || (cmd_i.op == DOP_ACC_ADD),
                   $past(cmd_i.op, 2) == DOP_MUL_X, "accumulate without matching product")
  `LUPS_ASSERT_IMP(a_sub_mul, cmd_i.wr && (cmd_i.wsel == WSEL_SUB),
                   $past(cmd_i.op, 2) == DOP_MUL_L, "update without matching product")
  `LUPS_ASSERT_NXT(a_emit_out, emit && out_free, out_valid_q, "emitted result lost")

endmodule

`default_nettype wire

/* rtl/core/lups_ctrl.sv */
// ----------------------------------------------------------------------------
// LU solver controller
// Load counters, order register and the sequencer for factor and solve.
// ----------------------------------------------------------------------------
`default_nettype none

module lups_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [4:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  lups_pkg::sts_t  sts_i,
  output lups_pkg::cmd_t  cmd_o
);
  import lups_pkg::*;

  typedef enum logic [39:0] {
    S_IDLE    = 40'b1 << 0,
    S_INIT    = 40'b1 << 1,
    S_PS_RD   = 40'b1 << 2,
    S_PS_CMP  = 40'b1 << 3,
    S_PS_CHK  = 40'b1 << 4,
    S_PP1     = 40'b1 << 5,
    S_PP2     = 40'b1 << 6,
    S_PP3     = 40'b1 << 7,
    S_SW_RA   = 40'b1 << 8,
    S_SW_RB   = 40'b1 << 9,
    S_SW_WA   = 40'b1 << 10,
    S_SW_WB   = 40'b1 << 11,
    S_EL_RDP  = 40'b1 << 12,
    S_EL_RDJ  = 40'b1 << 13,
    S_EL_DIV  = 40'b1 << 14,
    S_EL_DIVW = 40'b1 << 15,
    S_EL_K1   = 40'b1 << 16,
    S_EL_K2   = 40'b1 << 17,
    S_EL_K3   = 40'b1 << 18,
    S_EL_K4   = 40'b1 << 19,
    S_FIN_RD  = 40'b1 << 20,
    S_FIN_CHK = 40'b1 << 21,
    S_SING    = 40'b1 << 22,
    S_PX1     = 40'b1 << 23,
    S_PX2     = 40'b1 << 24,
    S_FI      = 40'b1 << 25,
    S_F1      = 40'b1 << 26,
    S_F2      = 40'b1 << 27,
    S_F3      = 40'b1 << 28,
    S_F4      = 40'b1 << 29,
    S_FW      = 40'b1 << 30,
    S_BI      = 40'b1 << 31,
    S_B1      = 40'b1 << 32,
    S_B2      = 40'b1 << 33,
    S_B3      = 40'b1 << 34,
    S_B4      = 40'b1 << 35,
    S_BD1     = 40'b1 << 36,
    S_BD2     = 40'b1 << 37,
    S_BD3     = 40'b1 << 38,
    S_OUT     = 40'b1 << 39
  } state_e;

  typedef enum logic [1:0] {
    LD_MAT,
    LD_RHS,
    LD_FULL
  } ld_phase_e;

  state_e          state_q, state_d;
  ld_phase_e       ph_q, ph_d;
  logic [CntW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [4:0]      size_q;
  logic [CntW-1:0] n, nm1;
  logic            accept;

  // Order zero counts as one; anything above the store size is clamped.
  assign n   = (size_q == '0) ? CntW'(1) :
               (size_q > CntW'(MaxOrder)) ? CntW'(MaxOrder) : size_q;
  assign nm1 = n - 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    cmd_o    = '0;
    cmd_o.op = DOP_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (ph_q)
            LD_MAT: begin
              cmd_o.wr   = 1'b1;
              cmd_o.wsel = WSEL_IN;
              cmd_o.row  = ld_row_q[IdxW-1:0];
              cmd_o.col  = ld_col_q[IdxW-1:0];
              if (ld_col_q == nm1) begin
                ld_col_d = '0;
                if (ld_row_q == nm1) begin
                  ph_d = LD_RHS;
                end else begin
                  ld_row_d = ld_row_q + 1'b1;
                end
              end else begin
                ld_col_d = ld_col_q + 1'b1;
              end
            end
            LD_RHS: begin
              cmd_o.op  = DOP_LOAD_RHS;
              cmd_o.col = ld_col_q[IdxW-1:0];
              if (ld_col_q == nm1) begin
                ph_d = LD_FULL;
              end else begin
                ld_col_d = ld_col_q + 1'b1;
              end
            end
            default: ;
          endcase
          if (in_last_i) begin
            ph_d     = LD_MAT;
            ld_row_d = '0;
            ld_col_d = '0;
            state_d  = S_INIT;
          end
        end
        if (cfg_we_i) begin
          ph_d     = LD_MAT;
          ld_row_d = '0;
          ld_col_d = '0;
        end
      end
      S_INIT: begin
        cmd_o.op = DOP_PERM_INIT;
        i_d = '0;
        j_d = '0;
        state_d = (n == CntW'(1)) ? S_FIN_RD : S_PS_RD;
      end
      S_PS_RD: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = j_q[IdxW-1:0];
        cmd_o.col = i_q[IdxW-1:0];
        state_d = S_PS_CMP;
      end
      S_PS_CMP: begin
        cmd_o.op    = DOP_SEARCH;
        cmd_o.row   = j_q[IdxW-1:0];
        cmd_o.first = (j_q == i_q);
        if (j_q == nm1) begin
          state_d = S_PS_CHK;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_PS_RD;
        end
      end
      S_PS_CHK: begin
        j_d = i_q + 1'b1;
        k_d = '0;
        if (sts_i.piv_zero) begin
          state_d = S_SING;
        end else if (sts_i.best != i_q[IdxW-1:0]) begin
          state_d = S_PP1;
        end else begin
          state_d = S_EL_RDP;
        end
      end
      S_PP1: begin
        cmd_o.op  = DOP_PERM_CAP;
        cmd_o.row = i_q[IdxW-1:0];
        state_d = S_PP2;
      end
      S_PP2: begin
        cmd_o.op  = DOP_PERM_FROM_BEST;
        cmd_o.row = i_q[IdxW-1:0];
        state_d = S_PP3;
      end
      S_PP3: begin
        cmd_o.op  = DOP_PERM_PUT;
        cmd_o.row = sts_i.best;
        state_d = S_SW_RA;
      end
      S_SW_RA: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = k_q[IdxW-1:0];
        state_d = S_SW_RB;
      end
      S_SW_RB: begin
        cmd_o.op  = DOP_CAP_A;
        cmd_o.rd  = 1'b1;
        cmd_o.row = sts_i.best;
        cmd_o.col = k_q[IdxW-1:0];
        state_d = S_SW_WA;
      end
      S_SW_WA: begin
        cmd_o.wr   = 1'b1;
        cmd_o.wsel = WSEL_RDATA;
        cmd_o.row  = i_q[IdxW-1:0];
        cmd_o.col  = k_q[IdxW-1:0];
        state_d = S_SW_WB;
      end
      S_SW_WB: begin
        cmd_o.wr   = 1'b1;
        cmd_o.wsel = WSEL_TA;
        cmd_o.row  = sts_i.best;
        cmd_o.col  = k_q[IdxW-1:0];
        if (k_q == nm1) begin
          state_d = S_EL_RDP;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_SW_RA;
        end
      end
      S_EL_RDP: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = i_q[IdxW-1:0];
        state_d = S_EL_RDJ;
      end
      S_EL_RDJ: begin
        cmd_o.op  = DOP_CAP_B;
        cmd_o.rd  = 1'b1;
        cmd_o.row = j_q[IdxW-1:0];
        cmd_o.col = i_q[IdxW-1:0];
        state_d = S_EL_DIV;
      end
      S_EL_DIV: begin
        cmd_o.op = DOP_DIV_MAT;
        state_d = S_EL_DIVW;
      end
      S_EL_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.op   = DOP_CAP_L;
          cmd_o.wr   = 1'b1;
          cmd_o.wsel = WSEL_QUOT;
          cmd_o.row  = j_q[IdxW-1:0];
          cmd_o.col  = i_q[IdxW-1:0];
          k_d = i_q + 1'b1;
          state_d = S_EL_K1;
        end
      end
      S_EL_K1: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = k_q[IdxW-1:0];
        state_d = S_EL_K2;
      end
      S_EL_K2: begin
        cmd_o.op  = DOP_MUL_L;
        cmd_o.rd  = 1'b1;
        cmd_o.row = j_q[IdxW-1:0];
        cmd_o.col = k_q[IdxW-1:0];
        state_d = S_EL_K3;
      end
      S_EL_K3: begin
        cmd_o.op = DOP_CAP_B;
        state_d = S_EL_K4;
      end
      S_EL_K4: begin
        cmd_o.wr   = 1'b1;
        cmd_o.wsel = WSEL_SUB;
        cmd_o.row  = j_q[IdxW-1:0];
        cmd_o.col  = k_q[IdxW-1:0];
        if (k_q != nm1) begin
          k_d = k_q + 1'b1;
          state_d = S_EL_K1;
        end else if (j_q != nm1) begin
          j_d = j_q + 1'b1;
          state_d = S_EL_RDP;
        end else if (i_q + 1'b1 == nm1) begin
          state_d = S_FIN_RD;
        end else begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
          state_d = S_PS_RD;
        end
      end
      S_FIN_RD: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = nm1[IdxW-1:0];
        cmd_o.col = nm1[IdxW-1:0];
        state_d = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        i_d = '0;
        state_d = sts_i.rdata_zero ? S_SING : S_PX1;
      end
      S_SING: begin
        if (sts_i.out_free) begin
          cmd_o.op = DOP_EMIT_SING;
          state_d = S_IDLE;
        end
      end
      S_PX1: begin
        cmd_o.op  = DOP_PERM_CAP;
        cmd_o.row = i_q[IdxW-1:0];
        state_d = S_PX2;
      end
      S_PX2: begin
        cmd_o.op  = DOP_X_FROM_RHS;
        cmd_o.row = i_q[IdxW-1:0];
        if (i_q == nm1) begin
          i_d = '0;
          state_d = S_FI;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_PX1;
        end
      end
      S_FI: begin
        cmd_o.op  = DOP_ACC_LOAD_X;
        cmd_o.row = i_q[IdxW-1:0];
        j_d = '0;
        state_d = (i_q == '0) ? S_FW : S_F1;
      end
      S_F1: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = j_q[IdxW-1:0];
        state_d = S_F2;
      end
      S_F2: begin
        cmd_o.op  = DOP_MUL_X;
        cmd_o.col = j_q[IdxW-1:0];
        state_d = S_F3;
      end
      S_F3: begin
        state_d = S_F4;
      end
      S_F4: begin
        cmd_o.op = DOP_ACC_SUB;
        if (j_q + 1'b1 == i_q) begin
          state_d = S_FW;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_F1;
        end
      end
      S_FW: begin
        cmd_o.op  = DOP_X_FROM_ACC;
        cmd_o.row = i_q[IdxW-1:0];
        if (i_q == nm1) begin
          state_d = S_BI;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_FI;
        end
      end
      S_BI: begin
        cmd_o.op = DOP_ACC_CLEAR;
        j_d = i_q + 1'b1;
        state_d = (i_q == nm1) ? S_BD1 : S_B1;
      end
      S_B1: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = j_q[IdxW-1:0];
        state_d = S_B2;
      end
      S_B2: begin
        cmd_o.op  = DOP_MUL_X;
        cmd_o.col = j_q[IdxW-1:0];
        state_d = S_B3;
      end
      S_B3: begin
        state_d = S_B4;
      end
      S_B4: begin
        cmd_o.op = DOP_ACC_ADD;
        if (j_q == nm1) begin
          state_d = S_BD1;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_B1;
        end
      end
      S_BD1: begin
        cmd_o.rd  = 1'b1;
        cmd_o.row = i_q[IdxW-1:0];
        cmd_o.col = i_q[IdxW-1:0];
        state_d = S_BD2;
      end
      S_BD2: begin
        cmd_o.op  = DOP_DIV_BACK;
        cmd_o.row = i_q[IdxW-1:0];
        state_d = S_BD3;
      end
      S_BD3: begin
        if (sts_i.div_done) begin
          cmd_o.op  = DOP_X_FROM_QUOT;
          cmd_o.row = i_q[IdxW-1:0];
          if (i_q == '0) begin
            state_d = S_OUT;
          end else begin
            i_d = i_q - 1'b1;
            state_d = S_BI;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = DOP_EMIT;
          cmd_o.row  = i_q[IdxW-1:0];
          cmd_o.last = (i_q == nm1);
          if (i_q == nm1) begin
            state_d = S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= LD_MAT;
      ld_row_q <= '0;
      ld_col_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      size_q   <= 5'(MaxOrder);
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lu_pivot_linear_solver_top.sv */
// Solves A x = b in Q16.16 for an order n of 1 to 16 set by the size register.
// Stream in the n*n matrix elements row by row and then the n right-hand side
// elements, one transfer per cycle, with tlast on the final one; that starts the
// solve, during which no input is taken. The solve factors with partial pivoting,
// every matrix update goes through the single-port matrix memory and each divide
// uses the bit-serial divider. Then x[0] to x[n-1] leave one per cycle as the
// consumer takes them, tlast on x[n-1]; a zero pivot gives a single result with
// tuser set.
// ----------------------------------------------------------------------------
// LU solver top level
// Stream ports, configuration register port and the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_pivot_linear_solver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // size_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [31:0] solution, [35:32] index, rest zero
  output logic        m_axis_tuser,    // [0] singular
  output logic        m_axis_tlast
);
  import lups_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [DataW-1:0] sol;
  logic [IdxW-1:0]  idx;

  lups_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lups_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (s_axis_tdata),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_solution_o (sol),
    .out_index_o    (idx),
    .out_singular_o (m_axis_tuser),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'h0, idx, sol};

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LU solver testbench
// Loads Q16.16 systems of several orders: directed corner cases first, then
// random well-formed, singular, raw full-range, short and overlong loads. Each
// output is checked against an in-bench fixed-point LU solver or typed answer.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned IdleLimit   = 150000;
  localparam int unsigned SettleCyc   = 64;

  typedef struct {
    int       sol;
    bit [3:0] idx;
    bit       sing;
    bit       eor;
  } answer_t;

  typedef struct {
    bit          is_cfg;
    bit [4:0]    cfg;
    bit [31:0]   value;
    bit          is_last;
    bit          typed;
    answer_t     ans;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  lu_pivot_linear_solver_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Solver state mirrored in the bench.
  int          a_mat [16][16];
  int          b_vec [16];
  int unsigned size_reg;
  int unsigned load_cnt;

  answer_t     answers_q [$];
  stim_t       directed_q [$];
  stim_t       pending_q [$];
  bit          feeding;
  bit          calm;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned covered;

  function automatic int from_mag(longint unsigned m, bit neg);
    if (!neg) return (m > 64'd2147483647) ? 32'h7FFF_FFFF : int'(m);
    if (m >= 64'd2147483648) return 32'h8000_0000;
    return -int'(m);
  endfunction

  function automatic longint unsigned abs_of(int v);
    longint w;
    w = v;
    return (w < 0) ? longint'(-w) : longint'(w);
  endfunction

  function automatic int clamp_add(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int q_mul(int a, int b);
    longint unsigned m;
    m = abs_of(a) * abs_of(b);
    return from_mag((m + 64'd32768) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic int q_div(int a, int b);
    longint unsigned num, den;
    num = abs_of(a) << 16;
    den = abs_of(b);
    if (den == 0) return 0;
    return from_mag((num + den / 2) / den, (a < 0) != (b < 0));
  endfunction

  function automatic int unsigned order_of(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > 16) return 16;
    return raw;
  endfunction

  // Factor, permute, substitute; pushes the expected transfers.
  task automatic solve_system(int unsigned n);
    int          perm [16];
    int          xv [16];
    int          t, sum;
    int unsigned best;
    longint unsigned bm, m;
    bit          ok;
    answer_t     ans;
    for (int i = 0; i < 16; i++) perm[i] = i;
    ok = 1'b1;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      best = i;
      bm = abs_of(a_mat[i][i]);
      for (int unsigned j = i + 1; j < n; j++) begin
        m = abs_of(a_mat[j][i]);
        if (m > bm) begin
          bm = m;
          best = j;
        end
      end
      if (bm == 0) begin
        ok = 1'b0;
        break;
      end
      if (best != i) begin
        t = perm[i]; perm[i] = perm[best]; perm[best] = t;
        for (int unsigned k = 0; k < n; k++) begin
          t = a_mat[i][k]; a_mat[i][k] = a_mat[best][k]; a_mat[best][k] = t;
        end
      end
      for (int unsigned j = i + 1; j < n; j++) begin
        a_mat[j][i] = q_div(a_mat[j][i], a_mat[i][i]);
        for (int unsigned k = i + 1; k < n; k++)
          a_mat[j][k] = clamp_add(longint'(a_mat[j][k]) - q_mul(a_mat[j][i], a_mat[i][k]));
      end
    end
    if (ok && a_mat[n-1][n-1] == 0) ok = 1'b0;
    if (!ok) begin
      ans = '{sol: 0, idx: 4'd0, sing: 1'b1, eor: 1'b1};
      answers_q.push_back(ans);
      return;
    end
    for (int unsigned i = 0; i < n; i++) xv[i] = b_vec[perm[i]];
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < i; j++)
        xv[i] = clamp_add(longint'(xv[i]) - q_mul(a_mat[i][j], xv[j]));
    for (int i = n - 1; i >= 0; i--) begin
      sum = 0;
      for (int unsigned j = i + 1; j < n; j++)
        sum = clamp_add(longint'(sum) + q_mul(a_mat[i][j], xv[j]));
      xv[i] = q_div(clamp_add(longint'(xv[i]) - sum), a_mat[i][i]);
    end
    for (int unsigned i = 0; i < n; i++) begin
      b_vec[i] = xv[i];
      ans = '{sol: xv[i], idx: i[3:0], sing: 1'b0, eor: (i + 1 == n)};
      answers_q.push_back(ans);
    end
  endtask

  // Applies one accepted input transfer to the mirrored state.
  task automatic absorb_element(stim_t it);
    int unsigned n, total;
    n = order_of(size_reg);
    total = n * n + n;
    if (load_cnt < total) begin
      if (load_cnt < n * n) a_mat[load_cnt / n][load_cnt % n] = int'(it.value);
      else b_vec[load_cnt - n * n] = int'(it.value);
      load_cnt++;
    end
    if (!it.is_last) return;
    load_cnt = 0;
    if (it.typed) begin
      // Keep the mirrored state in step, but hold the block to the typed answer.
      solve_system(n);
      void'(answers_q.pop_back());
      answers_q.push_back(it.ans);
    end else begin
      solve_system(n);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: one item on the bus at a time, prediction at acceptance.
  initial begin
    stim_t       it;
    int unsigned gap;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    feeding = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        continue;
      end
      feeding = 1'b1;
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      it = pending_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.value;
      s_axis_tlast  <= it.is_last;
      do @(posedge clk_i); while (!s_axis_tready);
      absorb_element(it);
      feeding = 1'b0;
    end
  end

  // Output stall pattern.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 6) begin
        stall = $urandom_range(5, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) < 75);
      end
    end
  end

  // Solution checker.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_q.size() == 0) begin
        report_mismatch("unexpected result, solution", m_axis_tdata[31:0], 0);
      end else begin
        want = answers_q.pop_front();
        if (m_axis_tdata[31:0] != want.sol)
          report_mismatch("solution", m_axis_tdata[31:0], want.sol);
        if (m_axis_tdata[35:32] != want.idx)
          report_mismatch("index", m_axis_tdata[35:32], want.idx);
        if (m_axis_tuser != want.sing) report_mismatch("singular", m_axis_tuser, want.sing);
        if (m_axis_tlast != want.eor) report_mismatch("end of run", m_axis_tlast, want.eor);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("lu_pivot_linear_solver_top verification failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || feeding || answers_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_size(bit [4:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg = v;
    load_cnt = 0;
  endtask

  task automatic dir_cfg(bit [4:0] v);
    stim_t s;
    s = '{is_cfg: 1'b1, cfg: v, value: 0, is_last: 0, typed: 0, ans: '{0, 0, 0, 0}};
    directed_q.push_back(s);
  endtask

  task automatic dir_item(bit [31:0] v, bit l);
    stim_t s;
    s = '{is_cfg: 1'b0, cfg: 0, value: v, is_last: l, typed: 0, ans: '{0, 0, 0, 0}};
    directed_q.push_back(s);
  endtask

  task automatic dir_check(bit [31:0] v, int sol, bit sing);
    stim_t s;
    s = '{is_cfg: 1'b0, cfg: 0, value: v, is_last: 1'b1, typed: 1'b1,
          ans: '{sol, 4'd0, sing, 1'b1}};
    directed_q.push_back(s);
  endtask

  function automatic bit [31:0] signed_rand(int unsigned hi);
    int v;
    v = $urandom_range(0, hi);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Queues one system of order n. Kinds: 0 well formed, 1 singular,
  // 2 raw full range, 3 overlong, 4 short.
  task automatic queue_system(int unsigned n, int unsigned kind);
    int          perm [16];
    int          t;
    int unsigned j, zc, total, cnt;
    stim_t       s;
    for (int i = 0; i < 16; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    zc = $urandom_range(0, n - 1);
    total = n * n + n;
    if (kind == 3) total += $urandom_range(1, 3);
    if (kind == 4) total = $urandom_range(1, n * n + n - 1);
    cnt = 0;
    for (int unsigned k = 0; k < total; k++) begin
      s = '{is_cfg: 1'b0, cfg: 0, value: 0, is_last: (k + 1 == total), typed: 0,
            ans: '{0, 0, 0, 0}};
      if (kind == 2 || k >= n * n + n) s.value = $urandom;
      else if (k >= n * n) s.value = signed_rand(16 << 16);
      else if (kind == 1 && k % n == zc) s.value = 0;
      else if (perm[k / n] == k % n) begin
        s.value = $urandom_range(2 << 16, 8 << 16);
        if ($urandom_range(0, 1)) s.value = -s.value;
      end else s.value = signed_rand(1 << 16);
      pending_q.push_back(s);
      cnt++;
    end
    if (kind != 4 && n > covered) covered = n;
  endtask

  initial begin
    stim_t       s;
    int unsigned sent, n, kind, r, bigs;
    bit [4:0]    raw;
    rst_ni      = 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    errors      = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    covered     = 0;
    size_reg    = 16;
    load_cnt    = 0;
    for (int i = 0; i < 16; i++) begin
      b_vec[i] = 0;
      for (int k = 0; k < 16; k++) a_mat[i][k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Order one: plain divide, zero pivot, extreme operands.
    dir_cfg(5'd1);
    dir_item(32'h0001_0000, 1'b0);
    dir_check(32'h0002_0000, 32'h0002_0000, 1'b0);
    dir_item(32'h0000_0000, 1'b0);
    dir_check(32'h0000_0005, 0, 1'b1);
    dir_item(32'h7FFF_FFFF, 1'b0);
    dir_check(32'h8000_0000, 32'hFFFF_0000, 1'b0);
    // A size of zero behaves as order one.
    dir_cfg(5'd0);
    dir_item(32'h8000_0000, 1'b0);
    dir_item(32'h7FFF_FFFF, 1'b1);
    // Extra elements past the system are dropped.
    dir_item(32'h0003_0000, 1'b0);
    dir_item(32'h0006_0000, 1'b0);
    dir_item(32'hFFFF_FFFF, 1'b0);
    dir_item(32'h1234_5678, 1'b1);
    // A lone element with tlast solves against what the stores already hold.
    dir_item(32'hFFFE_0000, 1'b1);
    // Order two: aborted partial load, then a system that needs a row swap.
    dir_cfg(5'd2);
    dir_item(32'h0005_0000, 1'b0);
    dir_item(32'h0007_0000, 1'b0);
    dir_item(32'h0009_0000, 1'b0);
    dir_cfg(5'd2);
    dir_item(32'h0000_0000, 1'b0);
    dir_item(32'h0001_0000, 1'b0);
    dir_item(32'h0001_0000, 1'b0);
    dir_item(32'h0000_0000, 1'b0);
    dir_item(32'h0003_0000, 1'b0);
    dir_item(32'h0004_0000, 1'b1);

    foreach (directed_q[i]) begin
      s = directed_q[i];
      if (s.is_cfg) write_size(s.cfg);
      else pending_q.push_back(s);
    end

    // Random systems; the first one runs at the largest order.
    sent = 0;
    bigs = 0;
    while (sent < RandomItems) begin
      calm = ($urandom_range(0, 4) == 0);
      if (sent == 0) begin
        raw = 5'd31;
        bigs++;
        write_size(raw);
      end else if ($urandom_range(0, 99) < 45) begin
        r = $urandom_range(0, 99);
        if (r < 85) raw = $urandom_range(1, 5);
        else if (r < 90) raw = 5'd0;
        else if (r < 97 || bigs >= 2) raw = $urandom_range(6, 9);
        else begin
          raw = $urandom_range(0, 1) ? 5'd16 : 5'($urandom_range(17, 31));
          bigs++;
        end
        write_size(raw);
      end
      n = order_of(size_reg);
      r = $urandom_range(0, 99);
      if (r < 8 && n <= covered) kind = 4;
      else if (r < 15) kind = 3;
      else if (r < 24) kind = 1;
      else if (r < 32) kind = 2;
      else kind = 0;
      r = pending_q.size();
      queue_system(n, kind);
      sent += pending_q.size() - r;
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("lu_pivot_linear_solver_top verification clean");
    end else begin
      $display("lu_pivot_linear_solver_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
